/* rtl/sorted_table_search_engine_unit_defines.svh */
// assertion macros shared by the search engine rtl
`ifndef SORTED_TABLE_SEARCH_ENGINE_UNIT_DEFINES_SVH
`define SORTED_TABLE_SEARCH_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define STSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("search engine assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define STSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("search engine assertion failed");

`endif

/* rtl/stse_pkg.sv */
// shared constants, codes and controller/datapath interface types
`default_nettype none
package stse_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  // signed search bound width: holds -1 .. TABLE_DEPTH
  localparam int BND_W       = ADDR_W + 2;

  // field widths
  localparam int DATA_W      = 32;
  localparam int IDX_FIELD_W = 10;
  localparam int POS_W       = 10;
  localparam int CNT_W       = 11;
  localparam int S_TDATA_W   = 48;
  localparam int M_TDATA_W   = 16;

  // opcodes carried in s_tuser
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // configuration register indexes
  localparam logic CFG_COUNT = 1'b0;
  localparam logic CFG_MODE  = 1'b1;

  // search modes
  localparam logic MODE_BIDIR   = 1'b0;
  localparam logic MODE_CLASSIC = 1'b1;

  // bound update selection
  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_HI_LM,
    UPD_LO_LM,
    UPD_LO_RM,
    UPD_BOTH
  } upd_t;

  // result selection
  typedef enum logic [1:0] {
    RES_MISS,
    RES_LM,
    RES_RM
  } res_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic start;
    logic latch_mid;
    logic rd;
    logic rd_rm;
    logic latch_l;
    upd_t upd;
    logic res_set;
    res_t res_sel;
    logic push;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic mode;
    logic empty;
    logic rd_eq;
    logic rd_lt;
    logic lv_eq;
    logic lv_gt;
    logic out_full;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/stse_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none
module stse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/stse_dp.sv */
// search datapath: config registers, table memory, bounds, compares, output register
`default_nettype none
module stse_dp import stse_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_index,
  input  wire logic [CNT_W-1:0]       cfg_wdata,
  input  wire logic [S_TDATA_W-1:0]   s_tdata,
  output      logic                   m_tvalid,
  input  wire logic                   m_tready,
  output      logic [M_TDATA_W-1:0]   m_tdata,
  output      logic [0:0]             m_tuser,
  input  wire cmd_t                   cmd,
  output      sts_t                   sts
);

  logic [CNT_W-1:0]        element_count;
  logic                    search_mode;
  logic [IDX_FIELD_W-1:0]  in_idx;
  logic signed [DATA_W-1:0] in_val;
  logic signed [DATA_W-1:0] target;
  logic signed [DATA_W-1:0] rdata;
  logic signed [BND_W-1:0] lo, hi, lm, rm;
  logic signed [BND_W-1:0] half, lm_calc, rm_calc;
  logic [BND_W-1:0]        cnt_sat;
  logic                    wr_en;
  logic [ADDR_W-1:0]       raddr;
  logic                    lv_eq, lv_gt;
  logic                    res_found;
  logic [POS_W-1:0]        res_pos;

  assign in_idx = s_tdata[IDX_FIELD_W-1:0];
  assign in_val = s_tdata[IDX_FIELD_W+DATA_W-1:IDX_FIELD_W];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
      search_mode   <= MODE_BIDIR;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COUNT: element_count <= cfg_wdata;
        CFG_MODE:  search_mode   <= cfg_wdata[0];
        default:   element_count <= element_count;
      endcase
    end
  end

  // count clipped to table depth
  assign cnt_sat = (32'(element_count) > 32'(TABLE_DEPTH)) ? BND_W'(TABLE_DEPTH)
                                                           : BND_W'(element_count);

  // midpoints of the current range
  assign half    = (hi - lo) >>> 1;
  assign lm_calc = lo + half;
  assign rm_calc = hi - half;

  // table memory
  assign wr_en = cmd.load && (32'(in_idx) < 32'(TABLE_DEPTH));
  assign raddr = cmd.rd_rm ? ADDR_W'(rm) : ADDR_W'(lm_calc);

  stse_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (ADDR_W'(in_idx)),
    .wdata (in_val),
    .re    (cmd.rd),
    .raddr (raddr),
    .rdata (rdata)
  );

  // search bounds, midpoints and left probe flags
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      target <= in_val;
      lo     <= '0;
      hi     <= $signed(cnt_sat) - BND_W'(1);
    end else begin
      case (cmd.upd)
        UPD_HI_LM: hi <= lm - BND_W'(1);
        UPD_LO_LM: lo <= lm + BND_W'(1);
        UPD_LO_RM: lo <= rm + BND_W'(1);
        UPD_BOTH: begin
          lo <= lm + BND_W'(1);
          hi <= rm - BND_W'(1);
        end
        default: lo <= lo;
      endcase
    end
    if (cmd.latch_mid) begin
      lm <= lm_calc;
      rm <= rm_calc;
    end
    if (cmd.latch_l) begin
      lv_eq <= (rdata == target);
      lv_gt <= (rdata > target);
    end
  end

  // result of the finished search
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      case (cmd.res_sel)
        RES_LM: begin
          res_found <= 1'b1;
          res_pos   <= POS_W'(lm);
        end
        RES_RM: begin
          res_found <= 1'b1;
          res_pos   <= POS_W'(rm);
        end
        default: begin
          res_found <= 1'b0;
          res_pos   <= '0;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      m_tuser <= res_found;
      m_tdata <= M_TDATA_W'(res_pos);
    end
  end

  // status to the controller
  always_comb begin
    sts.mode     = search_mode;
    sts.empty    = (lo > hi);
    sts.rd_eq    = (rdata == target);
    sts.rd_lt    = (rdata < target);
    sts.lv_eq    = lv_eq;
    sts.lv_gt    = lv_gt;
    sts.out_full = m_tvalid && !m_tready;
  end

endmodule
`default_nettype wire

/* rtl/stse_ctrl.sv */
// search controller: request intake and probe round sequencing
`default_nettype none
module stse_ctrl import stse_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output      logic s_tready,
  input  wire logic opcode,
  input  wire sts_t sts,
  output      cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RD_L,
    ST_RD_R,
    ST_DONE
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  // commands and next state
  always_comb begin
    state_next    = state;
    cmd.load      = 1'b0;
    cmd.start     = 1'b0;
    cmd.latch_mid = 1'b0;
    cmd.rd        = 1'b0;
    cmd.rd_rm     = 1'b0;
    cmd.latch_l   = 1'b0;
    cmd.upd       = UPD_NONE;
    cmd.res_set   = 1'b0;
    cmd.res_sel   = RES_MISS;
    cmd.push      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (opcode == OP_SEARCH) begin
            cmd.start  = 1'b1;
            state_next = ST_CHECK;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      // range test and left (or only) probe read
      ST_CHECK: begin
        if (sts.empty) begin
          cmd.res_set = 1'b1;
          cmd.res_sel = RES_MISS;
          state_next  = ST_DONE;
        end else begin
          cmd.rd        = 1'b1;
          cmd.latch_mid = 1'b1;
          state_next    = ST_RD_L;
        end
      end
      ST_RD_L: begin
        if (sts.mode == MODE_CLASSIC) begin
          if (sts.rd_eq) begin
            cmd.res_set = 1'b1;
            cmd.res_sel = RES_LM;
            state_next  = ST_DONE;
          end else begin
            cmd.upd    = sts.rd_lt ? UPD_LO_LM : UPD_HI_LM;
            state_next = ST_CHECK;
          end
        end else begin
          cmd.latch_l = 1'b1;
          cmd.rd      = 1'b1;
          cmd.rd_rm   = 1'b1;
          state_next  = ST_RD_R;
        end
      end
      // both probes known: left match wins over right
      ST_RD_R: begin
        if (sts.lv_eq) begin
          cmd.res_set = 1'b1;
          cmd.res_sel = RES_LM;
          state_next  = ST_DONE;
        end else if (sts.rd_eq) begin
          cmd.res_set = 1'b1;
          cmd.res_sel = RES_RM;
          state_next  = ST_DONE;
        end else begin
          if (sts.lv_gt) begin
            cmd.upd = UPD_HI_LM;
          end else if (sts.rd_lt) begin
            cmd.upd = UPD_LO_RM;
          end else begin
            cmd.upd = UPD_BOTH;
          end
          state_next = ST_CHECK;
        end
      end
      ST_DONE: begin
        if (!sts.out_full) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/sorted_table_search_engine_unit.sv */
// Sorted table search engine: a 1024 x 32-bit signed table in a single-port-read RAM.
// A load request (s_tuser = 0) writes one entry and gives no result.
// A search request (s_tuser = 1) binary-searches entries 0 .. element_count-1 (count
// clipped to 1024) and returns one result. Each probe is one registered RAM read plus a
// compare; a classic round passes ST_CHECK and ST_RD_L, a bidirectional round adds
// ST_RD_R (left and right probes share the one read port), and ST_DONE hands over
// the result. The output register frees the engine while a result waits.
`default_nettype none
`include "sorted_table_search_engine_unit_defines.svh"
module sorted_table_search_engine_unit import stse_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration write port
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [CNT_W-1:0]     cfg_wdata,
  // request stream
  input  wire logic                 s_tvalid,
  output      logic                 s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,  // entry_index[9:0], data_value[41:10], zero pad
  input  wire logic [0:0]           s_tuser,  // opcode[0]
  // result stream
  output      logic                 m_tvalid,
  input  wire logic                 m_tready,
  output      logic [M_TDATA_W-1:0] m_tdata,  // position[9:0], zero pad
  output      logic [0:0]           m_tuser   // found[0]
);

  cmd_t cmd;
  sts_t sts;

  // controller
  stse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .opcode   (s_tuser[0]),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  stse_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .sts       (sts)
  );

  // checks
  `STSE_ASSERT_IMP(a_push_free, cmd.push, !sts.out_full)
  `STSE_ASSERT_IMP(a_start_req, cmd.start, s_tvalid && s_tready && (s_tuser[0] == OP_SEARCH))
  `STSE_ASSERT_NXT(a_push_shows, cmd.push, m_tvalid)
  `STSE_ASSERT_IMP(a_miss_zero, m_tvalid && !m_tuser[0], m_tdata == '0)

endmodule
`default_nettype wire
